>>> rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg - shared types and constants for the step pulse spreader
// Fixed field widths and the control group that drives each axis lane.
// ----------------------------------------------------------------------------
package spr_pkg;

    // fixed widths of the load fields
    localparam int TICKS_W = 16;
    localparam int STEP_W  = 17;

    // per-item strobes from the sequencer to the lanes
    typedef struct packed {
        logic mul_en;    // register the two products
        logic step_en;   // tick item: advance the pulse count on a hit
        logic start_en;  // move ends: load the next move
    } spr_ctl_t;

endpackage

>>> rtl/spr_lane.sv
// ----------------------------------------------------------------------------
// spr_lane - one axis of the step pulse spreader
// Holds the axis' pulse counts and decides whether this tick is a step tick.
// ----------------------------------------------------------------------------
module spr_lane #(
    parameter int TICK_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  spr_pkg::spr_ctl_t            ctl,
    input  logic [TICK_BITS-1:0]         tick,      // tick index in move
    input  logic [TICK_BITS-1:0]         span,      // running move ticks - 1
    input  logic [TICK_BITS-1:0]         new_span,  // next move ticks - 1
    input  logic [spr_pkg::STEP_W-1:0]   new_steps, // next move raw count
    output logic                         hit,
    output logic                         dir_next
);

    localparam int PW = 2 * TICK_BITS;
    localparam int CW = (TICK_BITS > spr_pkg::STEP_W) ? TICK_BITS : spr_pkg::STEP_W;

    logic [TICK_BITS-1:0] done_reg,  done_next;
    logic [TICK_BITS-1:0] total_reg, total_next;
    logic                 dir_reg;
    logic [PW-1:0]        due_prod_reg;   // span * done
    logic [PW-1:0]        lo_prod_reg;    // tick * total

    logic [PW:0]                hi_prod;
    logic [spr_pkg::STEP_W-1:0] mag;
    logic [CW-1:0]              mag_ext;
    logic [CW-1:0]              span_ext;
    logic [TICK_BITS-1:0]       mag_clamped;
    logic                       neg;
    logic                       new_dir;

    // tick == floor(span*done/total)  <=>  tick*total <= span*done < tick*total + total
    always_comb begin
        hi_prod = {1'b0, lo_prod_reg} + (PW+1)'(total_reg);
        hit = (done_reg != total_reg) && (total_reg != '0)
              && (lo_prod_reg <= due_prod_reg)
              && ({1'b0, due_prod_reg} < hi_prod);
    end

    // next move: magnitude clamped to ticks - 1, direction from sign
    always_comb begin
        neg         = new_steps[spr_pkg::STEP_W-1];
        mag         = neg ? (spr_pkg::STEP_W'(0) - new_steps) : new_steps;
        mag_ext     = CW'(mag);
        span_ext    = CW'(new_span);
        mag_clamped = (mag_ext > span_ext) ? new_span : TICK_BITS'(mag_ext);
        new_dir     = !neg && (new_steps != '0);
        dir_next    = ctl.start_en ? new_dir : dir_reg;
    end

    always_comb begin
        done_next  = done_reg;
        total_next = total_reg;
        priority if (ctl.start_en) begin
            done_next  = '0;
            total_next = mag_clamped;
        end else if (ctl.step_en && hit) begin
            done_next = done_reg + TICK_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            total_reg <= '0;
            dir_reg   <= 1'b0;
        end else begin
            done_reg  <= done_next;
            total_reg <= total_next;
            dir_reg   <= dir_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            due_prod_reg <= PW'(span) * PW'(done_reg);
            lo_prod_reg  <= PW'(tick) * PW'(total_reg);
        end
    end

endmodule

>>> rtl/three_axis_step_pulse_spreader.sv
// ----------------------------------------------------------------------------
// three_axis_step_pulse_spreader - evenly spaced step pulses for several axes
// Tick items produce step, direction and move-end levels; load items queue
// the next move (tick count plus one signed step count per axis).
// ----------------------------------------------------------------------------
//
//  channel   | dir | tdata (low bit up)                         | tuser
//  ----------+-----+--------------------------------------------+----------
//  s_axis    | in  | move_ticks[16], steps per axis[17] each     | opcode
//  m_axis    | out | pulse per axis, direction per axis,        | -
//            |     | move_end, queue_full                       |
//
//  Each item passes capture, one multiply stage and one compare and update
//  stage; each lane has two 16x16 (TICK_BITS squared) multipliers. A new
//  item is taken in the cycle after the result is registered.
//  A result waiting on m_axis holds only the compare stage of the next item.
//  Synchronous active-low reset: no move queued, an empty one-tick move runs.
//
module three_axis_step_pulse_spreader #(
    parameter int AXES      = 3,
    parameter int TICK_BITS = 16,
    localparam int DATA_W    = spr_pkg::TICKS_W + AXES * spr_pkg::STEP_W,
    localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8,
    localparam int OUT_W     = 2 * AXES + 2,
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input items
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // move_ticks, steps_a, steps_b, steps_c, ... (zero padding to bytes)
    input  logic [S_TDATA_W-1:0]    s_axis_tdata,
    // opcode: 0 tick, 1 queue next move
    input  logic                    s_axis_tuser,
    // result items
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // pulse_a.., direction_a.., move_end, queue_full (zero padding to bytes)
    output logic [M_TDATA_W-1:0]    m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_EVAL = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // captured item
    logic                        op_reg;
    logic [spr_pkg::TICKS_W-1:0] ticks_in_reg;
    logic [spr_pkg::STEP_W-1:0]  steps_in_reg [AXES];

    // running move
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [TICK_BITS-1:0] span_reg, span_next;     // active ticks - 1

    // waiting move
    logic                        qvalid_reg, qvalid_next;
    logic [spr_pkg::TICKS_W-1:0] qticks_reg;
    logic [spr_pkg::STEP_W-1:0]  qsteps_reg [AXES];

    // result register
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg;

    spr_pkg::spr_ctl_t    ctl;
    logic                 out_free;
    logic                 move_ends;
    logic [TICK_BITS-1:0] new_ticks;
    logic [TICK_BITS-1:0] new_span;
    logic [AXES-1:0]      lane_hit;
    logic [AXES-1:0]      lane_dir;
    logic [spr_pkg::STEP_W-1:0] lane_steps [AXES];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(m_data_reg);
    assign out_free      = !m_valid_reg || m_axis_tready;

    // tick index never passes span, so equality marks the last tick
    assign move_ends = !op_reg && (tick_reg == span_reg);

    // next move length: queued one, or an empty one-tick move; zero reads as one
    always_comb begin
        new_ticks = qvalid_reg ? TICK_BITS'(qticks_reg) : TICK_BITS'(1);
        new_span  = (new_ticks == '0) ? '0 : (new_ticks - TICK_BITS'(1));
    end

    always_comb begin
        state_next   = state_reg;
        ctl          = '0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        tick_next    = tick_reg;
        span_next    = span_reg;
        qvalid_next  = qvalid_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                ctl.mul_en = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (out_free) begin
                    ctl.step_en  = !op_reg;
                    ctl.start_en = move_ends;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                    priority if (op_reg) begin
                        qvalid_next = 1'b1;
                    end else if (move_ends) begin
                        tick_next   = '0;
                        span_next   = new_span;
                        qvalid_next = 1'b0;
                    end else begin
                        tick_next = tick_reg + TICK_BITS'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            tick_reg    <= '0;
            span_reg    <= '0;
            qvalid_reg  <= 1'b0;
            qticks_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tick_reg    <= tick_next;
            span_reg    <= span_next;
            qvalid_reg  <= qvalid_next;
            if (state_reg == S_EVAL && out_free && op_reg) begin
                qticks_reg <= ticks_in_reg;
            end
        end
    end

    // item capture
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            op_reg       <= s_axis_tuser;
            ticks_in_reg <= s_axis_tdata[spr_pkg::TICKS_W-1:0];
        end
    end

    // merge: lane findings and move status into one result
    always_ff @(posedge aclk) begin
        if (state_reg == S_EVAL && out_free) begin
            m_data_reg[AXES-1:0]      <= op_reg ? '0 : lane_hit;
            m_data_reg[2*AXES-1:AXES] <= lane_dir;
            m_data_reg[2*AXES]        <= move_ends;
            m_data_reg[2*AXES+1]      <= qvalid_next;
        end
    end

    for (genvar i = 0; i < AXES; i++) begin : g_axis
        localparam int LO = spr_pkg::TICKS_W + i * spr_pkg::STEP_W;

        always_ff @(posedge aclk) begin
            if (s_axis_tvalid && s_axis_tready) begin
                steps_in_reg[i] <= s_axis_tdata[LO +: spr_pkg::STEP_W];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qsteps_reg[i] <= '0;
            end else if (state_reg == S_EVAL && out_free && op_reg) begin
                qsteps_reg[i] <= steps_in_reg[i];
            end
        end

        // no move waiting: the empty move has no steps
        assign lane_steps[i] = qvalid_reg ? qsteps_reg[i] : '0;

        spr_lane #(
            .TICK_BITS (TICK_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .tick      (tick_reg),
            .span      (span_reg),
            .new_span  (new_span),
            .new_steps (lane_steps[i]),
            .hit       (lane_hit[i]),
            .dir_next  (lane_dir[i])
        );
    end

endmodule

>>> sim/spr_checker.sv
// ----------------------------------------------------------------------------
// spr_checker - prediction and checking for the step pulse spreader
// Watches both channels, predicts the pin levels of every accepted item and
// compares each result item against the oldest prediction.
// ----------------------------------------------------------------------------
package spr_tb_pkg;

    import spr_pkg::*;

    localparam int N_AXES       = 3;
    localparam int S_TDATA_BITS = ((TICKS_W + N_AXES * STEP_W + 7) / 8) * 8;
    localparam int M_TDATA_BITS = 8;
    localparam int S_PAD_BITS   = S_TDATA_BITS - TICKS_W - N_AXES * STEP_W;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } spr_opcode_e;

    // s_axis tdata, low bits first: move_ticks, steps_a, steps_b, steps_c
    typedef struct packed {
        logic [S_PAD_BITS-1:0]              pad;
        logic [N_AXES-1:0][STEP_W-1:0]      steps;
        logic [TICKS_W-1:0]                 ticks;
    } spr_load_t;

    // m_axis tdata, low bits first: pulses, directions, move_end, queue_full
    typedef struct packed {
        logic                               queue_full;
        logic                               move_end;
        logic [N_AXES-1:0]                  dir;
        logic [N_AXES-1:0]                  pulse;
    } spr_pins_t;

endpackage

module spr_checker
    import spr_pkg::*;
    import spr_tb_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [S_TDATA_BITS-1:0]     s_axis_tdata,
    input  logic                        s_axis_tuser,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [M_TDATA_BITS-1:0]     m_axis_tdata,
    output int unsigned                 fails,
    output int unsigned                 waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // running move
    logic [TICKS_W-1:0]                 tick_pos;
    logic [TICKS_W-1:0]                 move_len;
    logic [N_AXES-1:0][TICKS_W-1:0]     pulses_done;
    logic [N_AXES-1:0][TICKS_W-1:0]     pulses_due;
    logic [N_AXES-1:0]                  dir_pins;
    // waiting move
    logic [TICKS_W-1:0]                 next_ticks;
    logic [N_AXES-1:0][STEP_W-1:0]      next_steps;
    logic                               next_valid;

    spr_pins_t   pin_levels_q[$];
    int unsigned fail_cnt = 0;

    assign fails = fail_cnt;

    initial waiting = 0;

    task automatic clear_spreader();
        tick_pos    = '0;
        move_len    = TICKS_W'(1);
        pulses_done = '0;
        pulses_due  = '0;
        dir_pins    = '0;
        next_ticks  = '0;
        next_steps  = '0;
        next_valid  = 1'b0;
    endtask

    task automatic begin_move(input logic [TICKS_W-1:0] ticks,
                              input logic [N_AXES-1:0][STEP_W-1:0] counts);
        int unsigned mag;
        move_len = (ticks == '0) ? TICKS_W'(1) : ticks;
        tick_pos = '0;
        dir_pins = '0;
        for (int i = 0; i < N_AXES; i++) begin
            // sign-magnitude from two's complement; -65536 gives 65536
            mag = counts[i][STEP_W-1] ? (32'h20000 - 32'(counts[i])) : 32'(counts[i]);
            if (mag > 32'(move_len) - 1)
                mag = 32'(move_len) - 1;
            dir_pins[i]    = !counts[i][STEP_W-1] && (counts[i] != 0);
            pulses_done[i] = '0;
            pulses_due[i]  = mag[TICKS_W-1:0];
        end
    endtask

    task automatic predict_pins(input spr_opcode_e op, input spr_load_t item,
                                output spr_pins_t pins);
        int unsigned hit_tick;
        pins = '0;
        if (op == OP_LOAD) begin
            // a newer load simply overwrites the waiting move
            next_ticks = item.ticks;
            next_steps = item.steps;
            next_valid = 1'b1;
        end else begin
            for (int i = 0; i < N_AXES; i++) begin
                if (pulses_done[i] != pulses_due[i] && pulses_due[i] != 0) begin
                    hit_tick = ((32'(move_len) - 1) * 32'(pulses_done[i]))
                               / 32'(pulses_due[i]);
                    if (32'(tick_pos) == hit_tick) begin
                        pins.pulse[i]  = 1'b1;
                        pulses_done[i] = pulses_done[i] + 1'b1;
                    end
                end
            end
            if (tick_pos >= move_len - 1'b1) begin
                pins.move_end = 1'b1;
                if (next_valid) begin
                    begin_move(next_ticks, next_steps);
                    next_valid = 1'b0;
                end else begin
                    begin_move(TICKS_W'(1), '0);
                end
            end else begin
                tick_pos = tick_pos + 1'b1;
            end
        end
        pins.dir        = dir_pins;
        pins.queue_full = next_valid;
    endtask

    always @(posedge aclk) begin
        spr_pins_t want;
        spr_pins_t got;
        spr_pins_t fresh;
        if (!aresetn) begin
            clear_spreader();
            pin_levels_q.delete();
        end else begin
            // results first, so a stray result cannot match this edge's item
            if (m_axis_tvalid && m_axis_tready) begin
                got = spr_pins_t'(m_axis_tdata);
                if (pin_levels_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: result item %b with nothing expected", $realtime, got);
                    fail_cnt++;
                end else begin
                    want = pin_levels_q.pop_front();
                    if (got.pulse !== want.pulse || got.dir !== want.dir ||
                        got.move_end !== want.move_end ||
                        got.queue_full !== want.queue_full) begin
                        if (fail_cnt < 10)
                            $display({"%0t: pins mismatch: pulse exp %b got %b, dir exp %b got %b,",
                                      " move_end exp %b got %b, queue_full exp %b got %b"},
                                     $realtime, want.pulse, got.pulse, want.dir, got.dir,
                                     want.move_end, got.move_end,
                                     want.queue_full, got.queue_full);
                        fail_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_pins(spr_opcode_e'(s_axis_tuser), spr_load_t'(s_axis_tdata), fresh);
                pin_levels_q.push_back(fresh);
            end
        end
        waiting <= pin_levels_q.size();
    end

endmodule

>>> sim/tb_three_axis_step_pulse_spreader.sv
// ----------------------------------------------------------------------------
// tb_three_axis_step_pulse_spreader - stimulus and verdict for the spreader
// Directed loads and ticks first, then random moves with random idling on
// both channels; the checker beside the block predicts every result item.
// ----------------------------------------------------------------------------
module tb_three_axis_step_pulse_spreader;
    timeunit 1ns;
    timeprecision 1ps;

    import spr_pkg::*;
    import spr_tb_pkg::*;

    localparam int IDLE_LIMIT   = 2000;   // cycles with no item moving
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 1300;   // random part, before the wind-down

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    wire                        s_axis_tready;
    // move_ticks, steps_a, steps_b, steps_c (zero padding to bytes)
    logic [S_TDATA_BITS-1:0]    s_axis_tdata  = '0;
    // opcode
    logic                       s_axis_tuser  = OP_TICK;
    wire                        m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // pulse_a..c, direction_a..c, move_end, queue_full
    wire  [M_TDATA_BITS-1:0]    m_axis_tdata;

    int unsigned fails;
    int unsigned waiting;
    int unsigned items_sent = 0;
    bit          calm       = 1'b0;   // no idling on either side while set

    three_axis_step_pulse_spreader dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    spr_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fails         (fails),
        .waiting       (waiting)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // mostly no gap, some short ones, the odd long one
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver back-pressure, same gap profile as the sender
    always @(posedge aclk) begin
        int stall;
        if (stall > 0) begin
            stall         <= stall - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            stall         <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // valid stays high across back-to-back items; lowered only for a gap or a drain
    task automatic send_item(input spr_opcode_e op, input spr_load_t load);
        int n;
        n = pick_gap();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= load;
        s_axis_tuser  <= op;
        do @(posedge aclk); while (!s_axis_tready);
        items_sent++;
    endtask

    // tdata of a tick item is don't-care, so it carries noise
    task automatic send_tick();
        spr_load_t junk;
        junk       = S_TDATA_BITS'({$urandom, $urandom, $urandom});
        junk.pad   = '0;
        send_item(OP_TICK, junk);
    endtask

    task automatic send_load(input int ticks, input int a, input int b, input int c);
        spr_load_t load;
        load          = '0;
        load.ticks    = TICKS_W'(ticks);
        load.steps[0] = STEP_W'(a);
        load.steps[1] = STEP_W'(b);
        load.steps[2] = STEP_W'(c);
        send_item(OP_LOAD, load);
    endtask

    // hold the sender until every predicted item has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (waiting != 0);
    endtask

    // mostly short moves; zero and one length now and then
    function automatic int pick_ticks();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return $urandom_range(0, 1);
        if (r < 85)
            return $urandom_range(2, 24);
        if (r < 98)
            return $urandom_range(25, 120);
        return $urandom_range(121, 300);
    endfunction

    // signed count around the clamp limit of the move, extremes included
    function automatic int pick_steps(input int ticks);
        int unsigned r;
        int          lim;
        int          mag;
        bit          neg;
        r   = $urandom_range(0, 99);
        lim = (ticks > 1) ? ticks - 1 : 1;
        neg = $urandom_range(0, 1);
        if (r < 10)
            mag = 0;
        else if (r < 70)
            mag = $urandom_range(1, lim);
        else if (r < 85)
            mag = lim + $urandom_range(0, 3);
        else if (r < 95)
            mag = 65535;
        else begin
            mag = 65536;
            neg = 1'b1;
        end
        return neg ? -mag : mag;
    endfunction

    initial begin
        int ticks;
        int n;
        spr_load_t noise;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        send_tick();                                // reset's empty move ends
        send_load(0, 65535, -65536, 0);             // zero length, max/min counts
        send_load(1, 5, -5, 1);                     // replaces the waiting move
        send_tick();                                // one-tick move starts, all clamp
        send_tick();                                // ends, nothing queued: empty move
        send_load(4, 3, -3, 2);
        repeat (5) send_tick();
        send_load(5, 65535, -65536, -1);            // clamp on axes a and b
        repeat (6) send_tick();
        drain_results();

        // ---- random moves ----
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
                drain_results();
            if ($urandom_range(0, 5) == 0)
                calm = !calm;
            if ($urandom_range(0, 9) == 0) begin
                // no load: run out the current move, maybe some empty ones
                repeat ($urandom_range(1, 4)) send_tick();
            end else begin
                if ($urandom_range(0, 2) == 0) begin
                    // fully random move, overwritten by the next load
                    noise     = S_TDATA_BITS'({$urandom, $urandom, $urandom});
                    noise.pad = '0;
                    send_item(OP_LOAD, noise);
                end
                ticks = pick_ticks();
                send_load(ticks, pick_steps(ticks), pick_steps(ticks), pick_steps(ticks));
                n = (ticks > 1) ? ticks : 1;
                if ($urandom_range(0, 3) != 0)
                    n = n + $urandom_range(0, 2);
                else
                    n = $urandom_range(0, n);
                repeat (n) send_tick();
            end
        end

        // ---- wind-down and the longest move ----
        calm = 1'b0;
        drain_results();
        repeat (610) send_tick();                   // flush current and queued moves
        send_load(65535, 65535, -65536, 1);
        repeat (25) send_tick();                    // long move starts; axes a and b pulse on every tick
        send_load(65535, -1, 0, 65535);             // queued behind the long move
        send_tick();
        drain_results();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fails == 0 && waiting == 0)
            $display("[three_axis_step_pulse_spreader] OK");
        else
            $display("[three_axis_step_pulse_spreader] ERROR");
        $finish;
    end

    // watchdog: too long with no item moving on either channel
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[three_axis_step_pulse_spreader] ERROR");
        $finish;
    end

endmodule
